// File: sv/ipsb_pkg.sv
`timescale 1ns / 1ps

package ipsb_pkg;

  localparam int CoordW = 8;
  localparam int RectW  = 9;
  localparam int PixW   = 32;
  localparam int CfgDw  = 9;
  localparam int CfgIw  = 2;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_COPY  = 2'd2;
  localparam logic [1:0] KIND_NOP   = 2'd3;

  localparam logic [1:0] FMT_RGBA8 = 2'd0;
  localparam logic [1:0] FMT_RGBA4 = 2'd1;
  localparam logic [1:0] FMT_ETC1  = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FORMAT = 2'd1;
  localparam logic [1:0] STAT_RANGE  = 2'd2;

  localparam logic [CfgIw-1:0] REG_FORMAT = 2'd0;
  localparam logic [CfgIw-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CfgIw-1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ACCESS,
    ST_COMMIT,
    ST_DONE
  } blit_state_t;

  function automatic logic [PixW-1:0] rgba4_pack(input logic [PixW-1:0] v);
    rgba4_pack = {16'd0, v[31:28], v[23:20], v[15:12], v[7:4]};
  endfunction

  function automatic logic [PixW-1:0] rgba4_expand(input logic [PixW-1:0] p);
    rgba4_expand = {p[15:12], p[15:12], p[11:8], p[11:8],
                    p[7:4], p[7:4], p[3:0], p[3:0]};
  endfunction

endpackage

// File: sv/ipsb_in_if.sv
`timescale 1ns / 1ps

interface ipsb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] x_coord;
  logic [7:0] y_coord;
  logic [31:0] pixel_value;
  logic [7:0] src_x;
  logic [7:0] src_y;
  logic [8:0] rect_width;
  logic [8:0] rect_height;
  logic       mirror_x;
  logic       mirror_y;

  modport source (
    output valid, kind, x_coord, y_coord, pixel_value, src_x, src_y,
           rect_width, rect_height, mirror_x, mirror_y,
    input  ready
  );
  modport sink (
    input  valid, kind, x_coord, y_coord, pixel_value, src_x, src_y,
           rect_width, rect_height, mirror_x, mirror_y,
    output ready
  );
endinterface

// File: sv/ipsb_out_if.sv
`timescale 1ns / 1ps

interface ipsb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [1:0]  status;

  modport source (
    output valid, read_data, status,
    input  ready
  );
  modport sink (
    input  valid, read_data, status,
    output ready
  );
endinterface

// File: sv/image_pixel_store_blitter.sv
`timescale 1ns / 1ps

// Pixel store with single-pixel write and read and a mirrored rectangle copy. The image sits
// in one synchronous memory of STORE_DEPTH words, addressed row major as y * width + x. A write
// passes the setup, access and done states, a read setup, access, commit and done; a copy runs
// setup, then access and commit for every pixel, then done. The access state reads the source
// word out of the memory and the commit state writes it to the destination. Pixels are moved
// strictly in visiting order, so an overlapping copy sees its own earlier writes. One request is
// processed at a time; a finished result waits in the output register while the next request is
// taken. Out-of-image coordinates are reported with a range status and skipped.
module image_pixel_store_blitter #(
  parameter int STORE_DEPTH = 65536,
  parameter int MAX_DIM     = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ipsb_pkg::CfgIw-1:0]  cfg_index,
  input  logic [ipsb_pkg::CfgDw-1:0]  cfg_data,
  ipsb_in_if.sink                     in_ch,
  ipsb_out_if.source                  out_ch
);
  import ipsb_pkg::*;

  localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PW  = 2 * RectW;
  localparam int SW  = PW + 1;
  localparam int CW  = RectW + 1;
  localparam int EW  = 21;
  localparam int DMW = 11;

  logic [PixW-1:0] mem [STORE_DEPTH];
  logic [PixW-1:0] rdata_r;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [PixW-1:0] mem_wdata;

  blit_state_t state_r, state_nxt;

  logic [1:0]       fmt_r;
  logic [CfgDw-1:0] width_r, height_r;

  logic [1:0]        kind_r, kind_nxt;
  logic [CoordW-1:0] x_r, x_nxt, y_r, y_nxt, sx_r, sx_nxt, sy_r, sy_nxt;
  logic [PixW-1:0]   val_r, val_nxt;
  logic [RectW-1:0]  rw_r, rw_nxt, rh_r, rh_nxt;
  logic              mx_r, mx_nxt, my_r, my_nxt;
  logic [RectW-1:0]  col_r, col_nxt, row_r, row_nxt;

  logic [PW-1:0]     sprod_r, sprod_nxt, dprod_r, dprod_nxt;
  logic [RectW-1:0]  spx_r, spx_nxt, dpx_r, dpx_nxt;
  logic              sin_r, sin_nxt, din_r, din_nxt;

  logic [AW-1:0]     waddr_r, waddr_nxt;
  logic              wok_r, wok_nxt;
  logic              last_r, last_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic [PixW-1:0]   data_r, data_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [PixW-1:0]   out_data_r, out_data_nxt;
  logic [1:0]        out_stat_r, out_stat_nxt;

  logic [RectW-1:0]  w_eff, h_eff;
  logic [CW-1:0]     sxc, syc, dxc, dyc;
  logic [SW-1:0]     saddr, daddr;
  logic [EW-1:0]     saddr_x, daddr_x;
  logic              s_ok, d_ok;
  logic              in_acc;
  logic              is_rgba4;

  always_comb begin
    w_eff = width_r;
    h_eff = height_r;
    if (width_r == '0) begin
      w_eff = RectW'(1);
    end else if ({2'b00, width_r} > DMW'(MAX_DIM)) begin
      w_eff = RectW'(MAX_DIM);
    end
    if (height_r == '0) begin
      h_eff = RectW'(1);
    end else if ({2'b00, height_r} > DMW'(MAX_DIM)) begin
      h_eff = RectW'(MAX_DIM);
    end
  end

  assign is_rgba4 = (fmt_r == FMT_RGBA4);

  always_comb begin
    if (mx_r) begin
      sxc = CW'(sx_r) + CW'(rw_r) - CW'(1) - CW'(col_r);
    end else begin
      sxc = CW'(sx_r) + CW'(col_r);
    end
    if (my_r) begin
      syc = CW'(sy_r) + CW'(rh_r) - CW'(1) - CW'(row_r);
    end else begin
      syc = CW'(sy_r) + CW'(row_r);
    end
    dxc = CW'(x_r) + CW'(col_r);
    dyc = CW'(y_r) + CW'(row_r);
  end

  assign saddr   = SW'(sprod_r) + SW'(spx_r);
  assign daddr   = SW'(dprod_r) + SW'(dpx_r);
  assign saddr_x = EW'(saddr);
  assign daddr_x = EW'(daddr);
  assign s_ok    = sin_r && (saddr_x < EW'(STORE_DEPTH));
  assign d_ok    = din_r && (daddr_x < EW'(STORE_DEPTH));

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign in_acc           = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;
  assign out_ch.status    = out_stat_r;

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    val_nxt       = val_r;
    rw_nxt        = rw_r;
    rh_nxt        = rh_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    sprod_nxt     = sprod_r;
    spx_nxt       = spx_r;
    sin_nxt       = sin_r;
    dprod_nxt     = dprod_r;
    dpx_nxt       = dpx_r;
    din_nxt       = din_r;
    waddr_nxt     = waddr_r;
    wok_nxt       = wok_r;
    last_nxt      = last_r;
    stat_nxt      = stat_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    mem_re        = 1'b0;
    mem_raddr     = daddr_x[AW-1:0];
    mem_we        = 1'b0;
    mem_waddr     = daddr_x[AW-1:0];
    mem_wdata     = is_rgba4 ? rgba4_pack(val_r) : val_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          kind_nxt = in_ch.kind;
          x_nxt    = in_ch.x_coord;
          y_nxt    = in_ch.y_coord;
          val_nxt  = in_ch.pixel_value;
          sx_nxt   = in_ch.src_x;
          sy_nxt   = in_ch.src_y;
          rw_nxt   = in_ch.rect_width;
          rh_nxt   = in_ch.rect_height;
          mx_nxt   = in_ch.mirror_x;
          my_nxt   = in_ch.mirror_y;
          col_nxt  = '0;
          row_nxt  = '0;
          last_nxt = 1'b0;
          stat_nxt = STAT_OK;
          data_nxt = '0;
          if (in_ch.kind == KIND_NOP) begin
            state_nxt = ST_DONE;
          end else if (fmt_r >= FMT_ETC1) begin
            stat_nxt  = STAT_FORMAT;
            state_nxt = ST_DONE;
          end else if (in_ch.kind == KIND_COPY &&
                       (in_ch.rect_width == '0 || in_ch.rect_height == '0)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SETUP;
          end
        end
      end

      ST_SETUP: begin
        sprod_nxt = PW'(syc[RectW-1:0]) * PW'(w_eff);
        spx_nxt   = sxc[RectW-1:0];
        sin_nxt   = (sxc < CW'(w_eff)) && (syc < CW'(h_eff));
        dprod_nxt = PW'(dyc[RectW-1:0]) * PW'(w_eff);
        dpx_nxt   = dxc[RectW-1:0];
        din_nxt   = (dxc < CW'(w_eff)) && (dyc < CW'(h_eff));
        state_nxt = ST_ACCESS;
      end

      ST_ACCESS: begin
        waddr_nxt = daddr_x[AW-1:0];
        priority if (kind_r == KIND_WRITE) begin
          mem_we    = d_ok;
          if (!d_ok) begin
            stat_nxt = STAT_RANGE;
          end
          state_nxt = ST_DONE;
        end else if (kind_r == KIND_READ) begin
          mem_re    = d_ok;
          wok_nxt   = d_ok;
          if (!d_ok) begin
            stat_nxt = STAT_RANGE;
          end
          state_nxt = ST_COMMIT;
        end else begin
          mem_re    = s_ok && d_ok;
          mem_raddr = saddr_x[AW-1:0];
          wok_nxt   = s_ok && d_ok;
          if (!(s_ok && d_ok)) begin
            stat_nxt = STAT_RANGE;
          end
          if (RectW'(col_r + RectW'(1)) == rw_r) begin
            col_nxt = '0;
            if (RectW'(row_r + RectW'(1)) == rh_r) begin
              row_nxt  = '0;
              last_nxt = 1'b1;
            end else begin
              row_nxt = RectW'(row_r + RectW'(1));
            end
          end else begin
            col_nxt = RectW'(col_r + RectW'(1));
          end
          state_nxt = ST_COMMIT;
        end
      end

      ST_COMMIT: begin
        if (kind_r == KIND_READ) begin
          if (wok_r) begin
            data_nxt = is_rgba4 ? rgba4_expand(rdata_r) : rdata_r;
          end
          state_nxt = ST_DONE;
        end else begin
          mem_we    = wok_r;
          mem_waddr = waddr_r;
          mem_wdata = is_rgba4 ? {16'd0, rdata_r[15:0]} : rdata_r;
          sprod_nxt = PW'(syc[RectW-1:0]) * PW'(w_eff);
          spx_nxt   = sxc[RectW-1:0];
          sin_nxt   = (sxc < CW'(w_eff)) && (syc < CW'(h_eff));
          dprod_nxt = PW'(dyc[RectW-1:0]) * PW'(w_eff);
          dpx_nxt   = dxc[RectW-1:0];
          din_nxt   = (dxc < CW'(w_eff)) && (dyc < CW'(h_eff));
          state_nxt = last_r ? ST_DONE : ST_ACCESS;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r;
          out_stat_nxt  = stat_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      last_r      <= 1'b0;
      fmt_r       <= FMT_RGBA8;
      width_r     <= CfgDw'(256);
      height_r    <= CfgDw'(256);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      last_r      <= last_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FORMAT: fmt_r    <= cfg_data[1:0];
          REG_WIDTH:  width_r  <= cfg_data;
          REG_HEIGHT: height_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    val_r      <= val_nxt;
    rw_r       <= rw_nxt;
    rh_r       <= rh_nxt;
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    sprod_r    <= sprod_nxt;
    spx_r      <= spx_nxt;
    sin_r      <= sin_nxt;
    dprod_r    <= dprod_nxt;
    dpx_r      <= dpx_nxt;
    din_r      <= din_nxt;
    waddr_r    <= waddr_nxt;
    wok_r      <= wok_nxt;
    stat_r     <= stat_nxt;
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

endmodule

// File: tb/tb_image_pixel_store_blitter.sv
`timescale 1ns / 1ps

module tb_image_pixel_store_blitter;
  import ipsb_pkg::*;

  localparam int StoreDepth = 65536;
  localparam int MaxDim     = 256;
  localparam int CycleLimit = 3000000;

  localparam logic [1:0] FMT_RESERVED = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  x_coord;
    logic [7:0]  y_coord;
    logic [31:0] pixel_value;
    logic [7:0]  src_x;
    logic [7:0]  src_y;
    logic [8:0]  rect_width;
    logic [8:0]  rect_height;
    logic        mirror_x;
    logic        mirror_y;
  } pixel_req_t;

  typedef struct {
    logic [31:0] read_data;
    logic [1:0]  status;
  } pixel_reply_t;

  typedef struct {
    logic [1:0] fmt;
    logic [8:0] w;
    logic [8:0] h;
    int         items;
  } image_setup_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIw-1:0] cfg_index;
  logic [CfgDw-1:0] cfg_data;

  ipsb_in_if  in_ch();
  ipsb_out_if out_ch();

  image_pixel_store_blitter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow copy of the image and the register file.
  bit [31:0]    shadow_pixels [0:StoreDepth-1];
  bit           pixel_written [0:StoreDepth-1];
  logic [1:0]   cur_format = FMT_RGBA8;
  logic [8:0]   cur_width  = 9'd256;
  logic [8:0]   cur_height = 9'd256;
  pixel_reply_t awaited_replies [$];
  int           mismatches  = 0;
  int unsigned  cycle_count = 0;
  bit           steady      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int sel;
    if (steady) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 60);
  endfunction

  function automatic int eff_dim(input logic [8:0] v);
    if (v == 9'd0) return 1;
    if (v > MaxDim) return MaxDim;
    return int'(v);
  endfunction

  function automatic bit locate(input int xx, input int yy, output int addr);
    int w;
    int h;
    w = eff_dim(cur_width);
    h = eff_dim(cur_height);
    addr = 0;
    if (xx >= w || yy >= h) return 1'b0;
    addr = yy * w + xx;
    return addr < StoreDepth;
  endfunction

  function automatic logic [31:0] fetch_rgba8(input int addr);
    bit [31:0] p;
    p = shadow_pixels[addr];
    if (cur_format == FMT_RGBA8) return p;
    return {8'(p[15:12]) * 8'h11, 8'(p[11:8]) * 8'h11,
            8'(p[7:4]) * 8'h11, 8'(p[3:0]) * 8'h11};
  endfunction

  function automatic void put_pixel(input int addr, input logic [31:0] v);
    if (cur_format == FMT_RGBA8) shadow_pixels[addr] = v;
    else shadow_pixels[addr] = {16'd0, v[31:28], v[23:20], v[15:12], v[7:4]};
    pixel_written[addr] = 1'b1;
  endfunction

  // Walks a rectangle copy in visiting order. With commit clear it only tells
  // whether every source pixel it would read holds a written value.
  function automatic bit walk_copy(input pixel_req_t r, input bit commit,
                                   output bit skipped);
    bit fresh [int];
    bit safe;
    int px;
    int py;
    int sa;
    int da;
    safe = 1'b1;
    skipped = 1'b0;
    for (int row = 0; row < int'(r.rect_height); row++) begin
      for (int col = 0; col < int'(r.rect_width); col++) begin
        px = r.mirror_x ? int'(r.src_x) + int'(r.rect_width) - 1 - col
                        : int'(r.src_x) + col;
        py = r.mirror_y ? int'(r.src_y) + int'(r.rect_height) - 1 - row
                        : int'(r.src_y) + row;
        if (locate(px, py, sa) && locate(int'(r.x_coord) + col, int'(r.y_coord) + row, da))
        begin
          if (!pixel_written[sa] && !fresh.exists(sa)) safe = 1'b0;
          if (commit) put_pixel(da, fetch_rgba8(sa));
          else fresh[da] = 1'b1;
        end else begin
          skipped = 1'b1;
        end
      end
    end
    return safe;
  endfunction

  function automatic void predict_reply(input pixel_req_t r);
    pixel_reply_t reply;
    int addr;
    bit skipped;
    reply.read_data = '0;
    reply.status = STAT_OK;
    if (r.kind == KIND_NOP) begin
    end else if (cur_format >= FMT_ETC1) begin
      reply.status = STAT_FORMAT;
    end else begin
      case (r.kind)
        KIND_WRITE: begin
          if (locate(r.x_coord, r.y_coord, addr)) put_pixel(addr, r.pixel_value);
          else reply.status = STAT_RANGE;
        end
        KIND_READ: begin
          if (locate(r.x_coord, r.y_coord, addr)) reply.read_data = fetch_rgba8(addr);
          else reply.status = STAT_RANGE;
        end
        default: begin
          void'(walk_copy(r, 1'b1, skipped));
          if (skipped) reply.status = STAT_RANGE;
        end
      endcase
    end
    awaited_replies.push_back(reply);
  endfunction

  always @(posedge clk) begin : reply_check
    pixel_reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("unexpected result", out_ch.read_data, '0);
      end else begin
        want = awaited_replies.pop_front();
        if (out_ch.read_data !== want.read_data)
          report_mismatch("read_data", out_ch.read_data, want.read_data);
        if (out_ch.status !== want.status)
          report_mismatch("status", 32'(out_ch.status), 32'(want.status));
      end
    end
  end

  initial begin : result_backpressure
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_request(input pixel_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= r.kind;
    in_ch.x_coord     <= r.x_coord;
    in_ch.y_coord     <= r.y_coord;
    in_ch.pixel_value <= r.pixel_value;
    in_ch.src_x       <= r.src_x;
    in_ch.src_y       <= r.src_y;
    in_ch.rect_width  <= r.rect_width;
    in_ch.rect_height <= r.rect_height;
    in_ch.mirror_x    <= r.mirror_x;
    in_ch.mirror_y    <= r.mirror_y;
    do @(posedge clk); while (!in_ch.ready);
    predict_reply(r);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_image(input logic [1:0] fmt, input logic [8:0] w, input logic [8:0] h);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FORMAT;
    cfg_data  <= {7'd0, fmt};
    @(posedge clk);
    cur_format = fmt;
    cfg_index <= REG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cur_width = w;
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cur_height = h;
    cfg_we <= 1'b0;
  endtask

  function automatic pixel_req_t mk_pixel(input logic [1:0] kind, input logic [7:0] x,
                                          input logic [7:0] y, input logic [31:0] v);
    pixel_req_t r;
    r.kind        = kind;
    r.x_coord     = x;
    r.y_coord     = y;
    r.pixel_value = v;
    r.src_x       = 8'($urandom);
    r.src_y       = 8'($urandom);
    r.rect_width  = 9'($urandom_range(0, 256));
    r.rect_height = 9'($urandom_range(0, 256));
    r.mirror_x    = 1'($urandom);
    r.mirror_y    = 1'($urandom);
    return r;
  endfunction

  function automatic pixel_req_t mk_copy(input logic [7:0] x, input logic [7:0] y,
                                         input logic [7:0] sx, input logic [7:0] sy,
                                         input logic [8:0] rw, input logic [8:0] rh,
                                         input logic mx, input logic my);
    pixel_req_t r;
    r = mk_pixel(KIND_COPY, x, y, $urandom);
    r.src_x       = sx;
    r.src_y       = sy;
    r.rect_width  = rw;
    r.rect_height = rh;
    r.mirror_x    = mx;
    r.mirror_y    = my;
    return r;
  endfunction

  function automatic logic [7:0] pick_coord(input int eff);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) return 8'($urandom_range(0, (eff < 12 ? eff : 12) - 1));
    if (sel < 95) return 8'($urandom_range(0, eff - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // Reads and copies that would touch a never-written pixel become writes.
  function automatic pixel_req_t random_request();
    pixel_req_t r;
    int w;
    int h;
    int sel;
    int addr;
    bit skipped;
    w = eff_dim(cur_width);
    h = eff_dim(cur_height);
    sel = $urandom_range(0, 99);
    r.kind = sel < 34 ? KIND_WRITE : sel < 64 ? KIND_READ : sel < 95 ? KIND_COPY : KIND_NOP;
    r.x_coord     = pick_coord(w);
    r.y_coord     = pick_coord(h);
    r.src_x       = pick_coord(w);
    r.src_y       = pick_coord(h);
    r.pixel_value = $urandom;
    r.mirror_x    = 1'($urandom);
    r.mirror_y    = 1'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      r.rect_width  = 9'($urandom_range(0, 6));
      r.rect_height = 9'($urandom_range(0, 6));
    end else if (sel < 90) begin
      r.rect_width  = 9'($urandom_range(0, 20));
      r.rect_height = 9'($urandom_range(0, 20));
    end else if (sel < 95) begin
      r.rect_width  = 9'($urandom_range(100, 256));
      r.rect_height = 9'($urandom_range(0, 3));
    end else begin
      r.rect_width  = 9'($urandom_range(0, 3));
      r.rect_height = 9'($urandom_range(100, 256));
    end
    if (cur_format < FMT_ETC1) begin
      if (r.kind == KIND_READ && locate(r.x_coord, r.y_coord, addr) && !pixel_written[addr])
        r.kind = KIND_WRITE;
      if (r.kind == KIND_COPY && !walk_copy(r, 1'b0, skipped))
        r.kind = KIND_WRITE;
    end
    return r;
  endfunction

  task automatic test_pixel_extremes();
    send_request(mk_pixel(KIND_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF));
    send_request(mk_pixel(KIND_WRITE, 8'd255, 8'd255, 32'h0000_0000));
    send_request(mk_pixel(KIND_WRITE, 8'd255, 8'd0, 32'hA5A5_5A5A));
    send_request(mk_pixel(KIND_WRITE, 8'd0, 8'd255, 32'h1234_5678));
    send_request(mk_pixel(KIND_READ, 8'd0, 8'd0, $urandom));
    send_request(mk_pixel(KIND_READ, 8'd255, 8'd255, $urandom));
    send_request(mk_pixel(KIND_READ, 8'd255, 8'd0, $urandom));
    send_request(mk_pixel(KIND_READ, 8'd0, 8'd255, $urandom));
    send_request(mk_pixel(KIND_NOP, 8'($urandom), 8'($urandom), $urandom));
  endtask

  task automatic test_bounds_flags();
    set_image(FMT_RGBA8, 9'd3, 9'd2);
    send_request(mk_pixel(KIND_WRITE, 8'd3, 8'd0, $urandom));
    send_request(mk_pixel(KIND_READ, 8'd0, 8'd2, $urandom));
    send_request(mk_pixel(KIND_WRITE, 8'd2, 8'd1, $urandom));
    send_request(mk_pixel(KIND_READ, 8'd2, 8'd1, $urandom));
  endtask

  task automatic test_rgba4_packing();
    set_image(FMT_RGBA4, 9'd256, 9'd256);
    send_request(mk_pixel(KIND_WRITE, 8'd1, 8'd0, 32'hF0E1_D2C3));
    send_request(mk_pixel(KIND_READ, 8'd1, 8'd0, $urandom));
    send_request(mk_pixel(KIND_READ, 8'd255, 8'd0, $urandom));
  endtask

  task automatic test_format_lockout();
    set_image(FMT_ETC1, 9'd256, 9'd256);
    send_request(mk_pixel(KIND_WRITE, 8'd0, 8'd0, $urandom));
    send_request(mk_pixel(KIND_READ, 8'd0, 8'd0, $urandom));
    send_request(mk_copy(8'd0, 8'd0, 8'd0, 8'd0, 9'd0, 9'd0, 1'b0, 1'b0));
  endtask

  task automatic test_mirrored_copy();
    set_image(FMT_RGBA8, 9'd2, 9'd2);
    send_request(mk_pixel(KIND_WRITE, 8'd0, 8'd1, $urandom));
    send_request(mk_pixel(KIND_WRITE, 8'd1, 8'd1, $urandom));
    send_request(mk_copy(8'd0, 8'd0, 8'd0, 8'd0, 9'd2, 9'd2, 1'b1, 1'b1));
    send_request(mk_copy(8'd1, 8'd1, 8'd0, 8'd0, 9'd2, 9'd2, 1'b0, 1'b1));
    send_request(mk_copy(8'd0, 8'd0, 8'd0, 8'd0, 9'd256, 9'd256, 1'b0, 1'b0));
    send_request(mk_pixel(KIND_READ, 8'd0, 8'd0, $urandom));
    send_request(mk_pixel(KIND_READ, 8'd1, 8'd1, $urandom));
  endtask

  task automatic test_random_traffic();
    image_setup_t plan [10];
    plan = '{
      '{FMT_RGBA8,    9'd16,  9'd16,  190},
      '{FMT_RGBA4,    9'd1,   9'd1,   190},
      '{FMT_RGBA8,    9'd0,   9'd0,   190},
      '{FMT_RGBA4,    9'd256, 9'd256, 190},
      '{FMT_RGBA8,    9'd511, 9'd5,   190},
      '{FMT_ETC1,     9'd256, 9'd256, 50},
      '{FMT_RGBA4,    9'd37,  9'd300, 190},
      '{FMT_RESERVED, 9'd5,   9'd7,   50},
      '{FMT_RGBA8,    9'd7,   9'd3,   190},
      '{FMT_RGBA4,    9'd12,  9'd12,  190}
    };
    foreach (plan[p]) begin
      set_image(plan[p].fmt, plan[p].w, plan[p].h);
      for (int i = 0; i < plan[p].items; i++) begin
        if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        send_request(random_request());
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_FORMAT;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_NOP;
    in_ch.x_coord     <= '0;
    in_ch.y_coord     <= '0;
    in_ch.pixel_value <= '0;
    in_ch.src_x       <= '0;
    in_ch.src_y       <= '0;
    in_ch.rect_width  <= '0;
    in_ch.rect_height <= '0;
    in_ch.mirror_x    <= 1'b0;
    in_ch.mirror_y    <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pixel_extremes();
    test_bounds_flags();
    test_rgba4_packing();
    test_format_lockout();
    test_mirrored_copy();
    test_random_traffic();

    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
